### hw/rtl/cisc_pkg.sv
// Shared types, token codes, register indexes and lookup tables for the intent slot checker.
`timescale 1ns / 1ps
package cisc_pkg;

  localparam int unsigned TokenW   = 5;
  localparam int unsigned DevW     = 2;
  localparam int unsigned ZoneW    = 3;
  localparam int unsigned ActW     = 4;
  localparam int unsigned MaskW    = 13;
  localparam int unsigned MaxDev   = 4;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned NumLevels = 4;

  // token code boundaries
  localparam logic [TokenW-1:0] TokZoneLo     = 5'd4;
  localparam logic [TokenW-1:0] TokActLo      = 5'd8;
  localparam logic [TokenW-1:0] TokActHi      = 5'd20;
  localparam logic [TokenW-1:0] TokUnknown    = 5'd21;
  localparam logic [TokenW-1:0] TokSilence    = 5'd22;
  localparam logic [TokenW-1:0] TokCompoundLo = 5'd23;
  localparam logic [TokenW-1:0] TokCompoundHi = 5'd25;
  localparam logic [TokenW-1:0] TokSceneLo    = 5'd26;
  localparam logic [TokenW-1:0] TokSceneHi    = 5'd29;
  localparam logic [TokenW-1:0] TokUnrecog    = 5'd30;
  localparam logic [TokenW-1:0] TokEmpty      = 5'd31;
  localparam logic [TokenW-1:0] ZoneBias      = 5'd3;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgDev0Mask  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgDev1Mask  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgDev2Mask  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgDev3Mask  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgZonedMask = 3'd4;

  localparam logic [MaskW-1:0]  Dev0MaskRst  = 13'd7731;
  localparam logic [MaskW-1:0]  Dev1MaskRst  = 13'd259;
  localparam logic [MaskW-1:0]  Dev2MaskRst  = 13'd195;
  localparam logic [MaskW-1:0]  Dev3MaskRst  = 13'd12;
  localparam logic [MaxDev-1:0] ZonedMaskRst = 4'd1;

  typedef struct packed {
    logic [TokenW-1:0] token;
    logic              last;
  } in_word_t;

  typedef struct packed {
    logic            valid_res;
    logic [DevW-1:0] device;
    logic [ZoneW-1:0] zone;
    logic [ActW-1:0] action;
    logic            level;
  } out_word_t;

  typedef struct packed {
    logic [MaxDev-1:0][MaskW-1:0] action_mask;
    logic [MaxDev-1:0]            zoned_mask;
  } cfg_t;

  typedef struct packed {
    logic             dev_seen;
    logic [DevW-1:0]  dev;
    logic [ZoneW-1:0] zone;
    logic             act_seen;
    logic [ActW-1:0]  act;
    logic             rejected;
  } slots_t;

  function automatic logic [ZoneW-1:0] combo_zone(input logic [1:0] idx);
    logic [ZoneW-1:0] z;
    case (idx)
      2'd0:    z = 3'd1;
      2'd1:    z = 3'd3;
      2'd2:    z = 3'd4;
      default: z = 3'd0;
    endcase
    return z;
  endfunction

  function automatic logic [ZoneW-1:0] scene_zone(input logic [1:0] idx);
    logic [ZoneW-1:0] z;
    case (idx)
      2'd2:    z = 3'd4;
      default: z = 3'd0;
    endcase
    return z;
  endfunction

  function automatic logic [ActW-1:0] scene_action(input logic [1:0] idx);
    logic [ActW-1:0] a;
    case (idx)
      2'd0:    a = 4'd1;
      2'd3:    a = 4'd9;
      default: a = 4'd0;
    endcase
    return a;
  endfunction

endpackage

### hw/rtl/cisc_in_stage.sv
// Input register stage holding one token word ahead of the slot update.
`timescale 1ns / 1ps
module cisc_in_stage
  import cisc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_word_t in_data_i,
  input  logic     advance_i,
  output logic     vld_o,
  output in_word_t word_o
);

  logic     vld_q, vld_d;
  in_word_t word_q, word_d;
  logic     take;

  assign in_ready_o = !vld_q || advance_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    vld_d  = vld_q;
    word_d = word_q;
    if (take) begin
      vld_d  = 1'b1;
      word_d = in_data_i;
    end else if (advance_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign vld_o  = vld_q;
  assign word_o = word_q;

endmodule

### hw/rtl/cisc_slot_tracker.sv
// Slot registers, order and duplicate rules, and the final intent check.
`timescale 1ns / 1ps
module cisc_slot_tracker
  import cisc_pkg::*;
#(
  parameter int unsigned NUM_DEVICES = 4,
  parameter int unsigned NUM_ACTIONS = 13
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      fire_i,
  input  in_word_t  word_i,
  input  cfg_t      cfg_i,
  output out_word_t result_o
);

  localparam logic [TokenW-1:0] NumDevW = TokenW'(NUM_DEVICES);
  localparam logic [TokenW-1:0] NumActW = TokenW'(NUM_ACTIONS);

  slots_t            s_q, s_d;
  logic [TokenW-1:0] tok;
  logic [TokenW-1:0] act_idx;
  logic [TokenW-1:0] zone_idx;
  logic [TokenW-1:0] cmp_idx;
  logic [TokenW-1:0] scn_idx;
  logic              busy;
  logic [15:0]       dev_mask;
  logic              ok;
  logic [TokenW-1:0] lvl_sum;

  assign tok      = word_i.token;
  assign act_idx  = tok - TokActLo;
  assign zone_idx = tok - ZoneBias;
  assign cmp_idx  = tok - TokCompoundLo;
  assign scn_idx  = tok - TokSceneLo;
  assign busy     = s_q.dev_seen || (s_q.zone != '0) || s_q.act_seen;

  always_comb begin
    s_d = s_q;
    if (!s_q.rejected) begin
      if (tok < TokZoneLo) begin
        if (tok >= NumDevW || busy) begin
          s_d.rejected = 1'b1;
        end else begin
          s_d.dev_seen = 1'b1;
          s_d.dev      = tok[DevW-1:0];
        end
      end else if (tok < TokActLo) begin
        if ((s_q.zone != '0) || !s_q.dev_seen || s_q.act_seen) begin
          s_d.rejected = 1'b1;
        end else begin
          s_d.zone = zone_idx[ZoneW-1:0];
        end
      end else if (tok <= TokActHi) begin
        if (act_idx >= NumActW || s_q.act_seen) begin
          s_d.rejected = 1'b1;
        end else begin
          s_d.act_seen = 1'b1;
          s_d.act      = act_idx[ActW-1:0];
        end
      end else if (tok == TokUnknown || tok == TokSilence || tok == TokEmpty) begin
        s_d = s_q;
      end else if (tok <= TokCompoundHi) begin
        if (busy) begin
          s_d.rejected = 1'b1;
        end else begin
          s_d.dev_seen = 1'b1;
          s_d.dev      = '0;
          s_d.zone     = combo_zone(cmp_idx[1:0]);
        end
      end else if (tok <= TokSceneHi) begin
        if (busy) begin
          s_d.rejected = 1'b1;
        end else begin
          s_d.dev_seen = 1'b1;
          s_d.dev      = '0;
          s_d.zone     = scene_zone(scn_idx[1:0]);
          s_d.act_seen = 1'b1;
          s_d.act      = scene_action(scn_idx[1:0]);
        end
      end else begin
        s_d.rejected = 1'b1;
      end
    end
  end

  assign dev_mask = {{(16 - MaskW){1'b0}}, cfg_i.action_mask[s_d.dev]};
  assign lvl_sum  = {1'b0, s_d.act} + TokenW'(NumLevels);

  always_comb begin
    ok = !s_d.rejected && s_d.dev_seen && s_d.act_seen;
    if ((s_d.zone != '0) && !cfg_i.zoned_mask[s_d.dev]) begin
      ok = 1'b0;
    end
    if ({1'b0, s_d.act} >= NumActW) begin
      ok = 1'b0;
    end
    if (!dev_mask[s_d.act]) begin
      ok = 1'b0;
    end
    result_o = '0;
    if (ok) begin
      result_o.valid_res = 1'b1;
      result_o.device    = s_d.dev;
      result_o.zone      = s_d.zone;
      result_o.action    = s_d.act;
      result_o.level     = (lvl_sum >= NumActW);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_q <= '0;
    end else if (fire_i) begin
      s_q <= word_i.last ? '0 : s_d;
    end
  end

endmodule

### hw/rtl/command_intent_slot_checker.sv
// Top level of the command intent slot checker: config registers and result register.
`timescale 1ns / 1ps
// Takes one keyword token word per clock and returns one intent word for each
// token marked last. A token passes through the input register, then the slot
// update and the intent check, which are combinational and end in the result
// register. The sustained rate is one token per cycle while results are
// drained; a waiting result holds back the next last token, and with it the
// input, set by the single result register. Configuration writes take effect
// on the next cycle.
module command_intent_slot_checker
  import cisc_pkg::*;
#(
  parameter int unsigned NUM_DEVICES = 4,
  parameter int unsigned NUM_ACTIONS = 13
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_word_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_word_t          out_data_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [MaskW-1:0]   cfg_wdata_i
);

  cfg_t      cfg_q, cfg_d;
  logic      st_vld;
  in_word_t  st_word;
  logic      advance;
  logic      fire;
  out_word_t result;
  logic      out_vld_q, out_vld_d;
  out_word_t out_q, out_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgDev0Mask:  cfg_d.action_mask[0] = cfg_wdata_i;
        CfgDev1Mask:  cfg_d.action_mask[1] = cfg_wdata_i;
        CfgDev2Mask:  cfg_d.action_mask[2] = cfg_wdata_i;
        CfgDev3Mask:  cfg_d.action_mask[3] = cfg_wdata_i;
        CfgZonedMask: cfg_d.zoned_mask     = cfg_wdata_i[MaxDev-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.action_mask[0] <= Dev0MaskRst;
      cfg_q.action_mask[1] <= Dev1MaskRst;
      cfg_q.action_mask[2] <= Dev2MaskRst;
      cfg_q.action_mask[3] <= Dev3MaskRst;
      cfg_q.zoned_mask     <= ZonedMaskRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // hold a last token while the previous intent is still waiting
  assign advance = !st_word.last || !out_vld_q || out_ready_i;
  assign fire    = st_vld && advance;

  cisc_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .advance_i  (advance),
    .vld_o      (st_vld),
    .word_o     (st_word)
  );

  cisc_slot_tracker #(
    .NUM_DEVICES (NUM_DEVICES),
    .NUM_ACTIONS (NUM_ACTIONS)
  ) u_slot_tracker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .word_i   (st_word),
    .cfg_i    (cfg_q),
    .result_o (result)
  );

  always_comb begin
    out_vld_d = out_vld_q;
    out_d     = out_q;
    if (fire && st_word.last) begin
      out_vld_d = 1'b1;
      out_d     = result;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_q.valid_res) |->
      (out_q.device == '0 && out_q.zone == '0 && out_q.action == '0 && !out_q.level))
    else $error("invalid intent carries nonzero fields");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_ready_i && st_vld && st_word.last) |-> !fire)
    else $error("pending intent overwritten");

  a_dev_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.valid_res) |-> (int'(out_q.device) < NUM_DEVICES))
    else $error("intent device out of range");

  a_act_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.valid_res) |-> (int'(out_q.action) < NUM_ACTIONS))
    else $error("intent action out of range");

endmodule
